[src/adbd_pkg.sv]
// ----------------------------------------------------------------------------
// adbd_pkg
// Shared widths, block positions, work item type and predictor taps for the
// 4-bit block ADPCM decoder.
// ----------------------------------------------------------------------------
package adbd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned NibW    = 4;
  localparam int unsigned PosW    = 4;
  localparam int unsigned ShiftW  = 4;
  localparam int unsigned FiltW   = 3;
  localparam int unsigned FlagW   = 3;
  localparam int unsigned SampleW = 16;
  localparam int unsigned TapW    = 8;

  // byte positions inside a 16-byte block
  localparam logic [PosW-1:0] POS_HEADER = 4'd0;
  localparam logic [PosW-1:0] POS_FLAGS  = 4'd1;
  localparam logic [PosW-1:0] POS_FIRST  = 4'd2;
  localparam logic [PosW-1:0] POS_LAST   = 4'd15;

  // highest filter code with its own taps; codes above it mean no prediction
  localparam logic [FiltW-1:0] FILT_MAX = 3'd4;

  // flag bits of the second header byte
  localparam int unsigned FLAG_END    = 0;
  localparam int unsigned FLAG_REPEAT = 1;
  localparam int unsigned FLAG_START  = 2;

  // one data byte with everything its two samples need
  typedef struct packed {
    logic [ByteW-1:0]  data;
    logic [ShiftW-1:0] shift;
    logic [FiltW-1:0]  filt;
    logic              clear_hist;
    logic              start_mark;
    logic              end_mark;
    logic              loop_repeat;
  } work_t;

  // first tap (applied to the last sample), 1/64 units
  function automatic logic signed [TapW-1:0] tap_first(input logic [FiltW-1:0] filt);
    logic signed [TapW-1:0] c;
    case (filt)
      3'd1:    c = 8'sd60;
      3'd2:    c = 8'sd115;
      3'd3:    c = 8'sd98;
      3'd4:    c = 8'sd122;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  // second tap (applied to the sample before), 1/64 units
  function automatic logic signed [TapW-1:0] tap_second(input logic [FiltW-1:0] filt);
    logic signed [TapW-1:0] c;
    case (filt)
      3'd2:    c = -8'sd52;
      3'd3:    c = -8'sd55;
      3'd4:    c = -8'sd60;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

endpackage

[src/adbd_in_if.sv]
// ----------------------------------------------------------------------------
// adbd_in_if
// Byte stream channel: valid/ready handshake with one stream byte per
// transaction.
// ----------------------------------------------------------------------------
interface adbd_in_if;
  import adbd_pkg::*;

  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  data_byte;
  logic              stream_start;

  modport source (output valid, output data_byte, output stream_start, input ready);
  modport sink   (input valid, input data_byte, input stream_start, output ready);
endinterface

[src/adbd_out_if.sv]
// ----------------------------------------------------------------------------
// adbd_out_if
// Sample channel: valid/ready handshake with one decoded sample and its loop
// markers per transaction.
// ----------------------------------------------------------------------------
interface adbd_out_if;
  import adbd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] pcm_sample;
  logic                      last_of_pair;
  logic                      loop_start_here;
  logic                      loop_end_here;
  logic                      loop_repeat;

  modport source (output valid, output pcm_sample, output last_of_pair,
                  output loop_start_here, output loop_end_here, output loop_repeat,
                  input ready);
  modport sink   (input valid, input pcm_sample, input last_of_pair,
                  input loop_start_here, input loop_end_here, input loop_repeat,
                  output ready);
endinterface

[src/adbd_block_decoder_4bit_top.sv]
// ----------------------------------------------------------------------------
// adpcm_block_decoder_4bit
// Timing: a data byte loads the work register; its low sample and then its
//   high sample are registered; header bytes take one transaction, no output.
// Throughput: one sample per cycle unless the output stalls, set by the
//   single prediction/clamp unit that the history chain runs through.
// Reset: framing, header, flags, history and both valid flags clear at once.
// ----------------------------------------------------------------------------
module adpcm_block_decoder_4bit (
  input  logic       clk_i,
  input  logic       rst_ni,
  adbd_in_if.sink    in_chan,
  adbd_out_if.source out_chan
);
  import adbd_pkg::*;

  // Front end: tracks position in the 16-byte block. Header and flags bytes
  // are absorbed there; a data byte becomes a work item carrying its own copy
  // of shift, filter and loop markers, so a following header may update the
  // front end while the previous byte is still being decoded.
  work_t work;
  logic  work_valid;
  logic  work_ready;

  adbd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_chan.valid),
    .data_byte_i    (in_chan.data_byte),
    .stream_start_i (in_chan.stream_start),
    .in_ready_o     (in_chan.ready),
    .work_valid_o   (work_valid),
    .work_o         (work),
    .work_ready_i   (work_ready)
  );

  // Core: holds one work item, emits its low-nibble sample then its
  // high-nibble sample into the output register. A history clear requested
  // by stream_start rides with the next data byte, so earlier samples still
  // see the old history. The work register refills on the cycle the high
  // sample leaves, keeping the sample stream gap-free.
  adbd_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .work_valid_i      (work_valid),
    .work_i            (work),
    .work_ready_o      (work_ready),
    .out_valid_o       (out_chan.valid),
    .out_ready_i       (out_chan.ready),
    .pcm_sample_o      (out_chan.pcm_sample),
    .last_of_pair_o    (out_chan.last_of_pair),
    .loop_start_here_o (out_chan.loop_start_here),
    .loop_end_here_o   (out_chan.loop_end_here),
    .loop_repeat_o     (out_chan.loop_repeat)
  );

endmodule

[src/adbd_front.sv]
// ----------------------------------------------------------------------------
// adbd_front
// Block framing: tracks byte position, captures the header and flags bytes,
// and turns each data byte into a work item.
// ----------------------------------------------------------------------------
module adbd_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [adbd_pkg::ByteW-1:0]  data_byte_i,
  input  logic                        stream_start_i,
  output logic                        in_ready_o,
  output logic                        work_valid_o,
  output adbd_pkg::work_t             work_o,
  input  logic                        work_ready_i
);
  import adbd_pkg::*;

  logic [PosW-1:0]   pos_q, pos_d, pos_cur;
  logic [ShiftW-1:0] shift_q, shift_d;
  logic [FiltW-1:0]  filt_q, filt_d, filt_hdr;
  logic [FlagW-1:0]  flags_q, flags_d;
  logic              clr_pend_q, clr_pend_d;
  logic              clr_cur;
  logic              accept;
  logic              is_data;

  assign pos_cur  = stream_start_i ? POS_HEADER : pos_q;
  assign clr_cur  = stream_start_i | clr_pend_q;
  assign is_data  = (pos_cur != POS_HEADER) && (pos_cur != POS_FLAGS);
  assign filt_hdr = data_byte_i[6:4];

  assign in_ready_o   = work_ready_i;
  assign accept       = in_valid_i & work_ready_i;
  assign work_valid_o = in_valid_i & is_data;

  always_comb begin
    work_o.data        = data_byte_i;
    work_o.shift       = shift_q;
    work_o.filt        = filt_q;
    work_o.clear_hist  = clr_cur;
    work_o.start_mark  = (pos_cur == POS_FIRST) & flags_q[FLAG_START];
    work_o.end_mark    = (pos_cur == POS_LAST) & flags_q[FLAG_END];
    work_o.loop_repeat = (pos_cur == POS_LAST) & flags_q[FLAG_END] & flags_q[FLAG_REPEAT];
  end

  always_comb begin
    pos_d      = pos_q;
    shift_d    = shift_q;
    filt_d     = filt_q;
    flags_d    = flags_q;
    clr_pend_d = clr_pend_q;
    if (accept) begin
      pos_d = pos_cur + 4'd1;
      if (pos_cur == POS_HEADER) begin
        shift_d    = data_byte_i[ShiftW-1:0];
        filt_d     = (filt_hdr > FILT_MAX) ? '0 : filt_hdr;
        clr_pend_d = clr_cur;
      end else if (pos_cur == POS_FLAGS) begin
        flags_d    = data_byte_i[FlagW-1:0];
        clr_pend_d = clr_cur;
      end else begin
        clr_pend_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      shift_q    <= '0;
      filt_q     <= '0;
      flags_q    <= '0;
      clr_pend_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      shift_q    <= shift_d;
      filt_q     <= filt_d;
      flags_q    <= flags_d;
      clr_pend_q <= clr_pend_d;
    end
  end

endmodule

[src/adbd_core.sv]
// ----------------------------------------------------------------------------
// adbd_core
// Work register, sample datapath (scale, two-tap prediction, clamp), sample
// history and output register. One sample per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module adbd_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               work_valid_i,
  input  adbd_pkg::work_t                    work_i,
  output logic                               work_ready_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [adbd_pkg::SampleW-1:0] pcm_sample_o,
  output logic                               last_of_pair_o,
  output logic                               loop_start_here_o,
  output logic                               loop_end_here_o,
  output logic                               loop_repeat_o
);
  import adbd_pkg::*;

  work_t                     work_q;
  logic                      busy_q, busy_d;
  logic                      phase_q;
  logic                      adv, load;

  logic signed [SampleW-1:0] h1_q, h2_q, h1_e, h2_e;
  logic [NibW-1:0]           nib;
  logic signed [SampleW-1:0] base;
  logic signed [23:0]        p1, p2;
  logic signed [24:0]        acc;
  logic signed [18:0]        pred;
  logic signed [19:0]        val;
  logic signed [SampleW-1:0] sample;

  logic                      out_valid_q;
  logic signed [SampleW-1:0] pcm_q;
  logic                      last_q, lstart_q, lend_q, lrep_q;

  assign adv          = busy_q & (~out_valid_q | out_ready_i);
  assign work_ready_o = ~busy_q | (phase_q & adv);
  assign load         = work_valid_i & work_ready_o;

  always_comb begin
    busy_d = busy_q;
    if (load) begin
      busy_d = 1'b1;
    end else if (adv && phase_q) begin
      busy_d = 1'b0;
    end
  end

  // datapath
  always_comb begin
    nib  = phase_q ? work_q.data[7:4] : work_q.data[3:0];
    h1_e = (work_q.clear_hist && !phase_q) ? '0 : h1_q;
    h2_e = (work_q.clear_hist && !phase_q) ? '0 : h2_q;
    // nibble in the top bits, then the shift scales it down (floor for shift > 12)
    base = $signed({nib, 12'h000}) >>> work_q.shift;
    p1   = h1_e * tap_first(work_q.filt);
    p2   = h2_e * tap_second(work_q.filt);
    acc  = 25'(p1) + 25'(p2) + 25'sd32;
    pred = acc[24:6];
    val  = 20'(base) + 20'(pred);
    if (val > 20'sd32767) begin
      sample = 16'sh7fff;
    end else if (val < -20'sd32768) begin
      sample = 16'sh8000;
    end else begin
      sample = val[SampleW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_q     <= 1'b0;
      h1_q        <= '0;
      h2_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (adv) begin
        phase_q     <= ~phase_q;
        h1_q        <= sample;
        h2_q        <= h1_e;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      work_q <= work_i;
    end
    if (adv) begin
      pcm_q    <= sample;
      last_q   <= phase_q;
      lstart_q <= ~phase_q & work_q.start_mark;
      lend_q   <= phase_q & work_q.end_mark;
      lrep_q   <= phase_q & work_q.loop_repeat;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign pcm_sample_o      = pcm_q;
  assign last_of_pair_o    = last_q;
  assign loop_start_here_o = lstart_q;
  assign loop_end_here_o   = lend_q;
  assign loop_repeat_o     = lrep_q;

endmodule

[tb/tb_adpcm_block_decoder_4bit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_adpcm_block_decoder_4bit
// Streams 16-byte ADPCM blocks into the decoder through the byte channel and
// checks every sample transaction against an in-bench decoder model. A short
// table of hand-picked bytes comes first, then random blocks with broken and
// truncated framing mixed in, under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_adpcm_block_decoder_4bit;
  import adbd_pkg::*;

  localparam int RAND_ITEMS  = 1450;
  localparam int IDLE_LIMIT  = 2000;  // cycles with no transaction on either side
  localparam int HOLD_CYCLES = 300;   // long sink hold-off to back up the input
  localparam int LINGER      = 10;    // quiet cycles after the last sample
  localparam int DIR_N       = 26;

  // prediction taps in 1/64 units, indexed by the mapped filter code
  localparam int TAP_LAST [5] = '{0, 60, 115, 98, 122};
  localparam int TAP_PREV [5] = '{0, 0, -52, -55, -60};

  // one decoded sample with its markers, as seen on the output channel
  typedef struct packed {
    logic signed [SampleW-1:0] pcm;
    logic                      last_of_pair;
    logic                      start_mark;
    logic                      end_mark;
    logic                      loop_rep;
  } pcm_result_t;

  // directed row; lo/hi are the typed samples when typed is set
  typedef struct packed {
    logic [ByteW-1:0]          data;
    logic                      start;
    logic                      typed;
    logic signed [SampleW-1:0] lo;
    logic signed [SampleW-1:0] hi;
  } stim_row_t;

  // Hand-picked stream. Block one runs filter 0 / shift 0 so each sample is
  // just nibble << 12: both nibble extremes, all flags set so the first and
  // last samples carry the loop markers. Then short blocks: filter code 5
  // mapped to no prediction with shift 12, filter 7 with shift 15 (nibble
  // shifted right, rounding toward minus infinity), and filter 4 driven into
  // both clamp rails.
  localparam stim_row_t DIR_TAB [DIR_N] = '{
    '{8'h00, 1'b1, 1'b0, 16'sd0,      16'sd0},
    '{8'h07, 1'b0, 1'b0, 16'sd0,      16'sd0},
    '{8'h87, 1'b0, 1'b1, 16'sd28672,  -16'sd32768},
    '{8'h78, 1'b0, 1'b1, -16'sd32768, 16'sd28672},
    '{8'h11, 1'b0, 1'b1, 16'sd4096,   16'sd4096},
    '{8'h0F, 1'b0, 1'b1, -16'sd4096,  16'sd0},
    '{8'h23, 1'b0, 1'b1, 16'sd12288,  16'sd8192},
    '{8'hF0, 1'b0, 1'b1, 16'sd0,      -16'sd4096},
    '{8'h9A, 1'b0, 1'b1, -16'sd24576, -16'sd28672},
    '{8'h00, 1'b0, 1'b1, 16'sd0,      16'sd0},
    '{8'h44, 1'b0, 1'b1, 16'sd16384,  16'sd16384},
    '{8'hC5, 1'b0, 1'b1, 16'sd20480,  -16'sd16384},
    '{8'h6B, 1'b0, 1'b1, -16'sd20480, 16'sd24576},
    '{8'hE1, 1'b0, 1'b1, 16'sd4096,   -16'sd8192},
    '{8'h3D, 1'b0, 1'b1, -16'sd12288, 16'sd12288},
    '{8'hFF, 1'b0, 1'b1, -16'sd4096,  -16'sd4096},
    '{8'h5C, 1'b1, 1'b0, 16'sd0,      16'sd0},
    '{8'h02, 1'b0, 1'b0, 16'sd0,      16'sd0},
    '{8'h8F, 1'b0, 1'b1, -16'sd1,     -16'sd8},
    '{8'h7F, 1'b1, 1'b0, 16'sd0,      16'sd0},
    '{8'h00, 1'b0, 1'b0, 16'sd0,      16'sd0},
    '{8'h18, 1'b0, 1'b1, -16'sd1,     16'sd0},
    '{8'h40, 1'b1, 1'b0, 16'sd0,      16'sd0},
    '{8'h04, 1'b0, 1'b0, 16'sd0,      16'sd0},
    '{8'h77, 1'b0, 1'b0, 16'sd0,      16'sd0},
    '{8'h88, 1'b0, 1'b0, 16'sd0,      16'sd0}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  adbd_in_if  in_if ();
  adbd_out_if out_if ();

  adpcm_block_decoder_4bit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Decoder model: framing, header and history as the block keeps them
  // --------------------------------------------------------------------------
  logic [PosW-1:0]           m_pos   = '0;
  logic [ShiftW-1:0]         m_shift = '0;
  logic [FiltW-1:0]          m_filt  = '0;
  logic [FlagW-1:0]          m_flags = '0;
  logic signed [SampleW-1:0] m_h1    = '0;
  logic signed [SampleW-1:0] m_h2    = '0;

  pcm_result_t pcm_expected_q [$];

  int  n_errors  = 0;
  int  n_sent    = 0;
  int  send_gap  = 0;
  bit  calm      = 1'b0;  // set: neither side idles for this stretch
  bit  hold_req  = 1'b0;  // sender asks the sink for one long hold-off
  bit  tb_live   = 1'b0;

  // one sample: scaled nibble plus rounded two-tap prediction, clamped
  function automatic logic signed [SampleW-1:0] next_sample(input logic [NibW-1:0] nib);
    int ns, sh, base, pred, sum;
    ns = int'($signed(nib));
    sh = int'(m_shift);
    if (sh <= 12) base = ns * (1 << (12 - sh));
    else          base = ns >>> (sh - 12);  // floor for negative nibbles
    pred = (int'(m_h1) * TAP_LAST[m_filt] + int'(m_h2) * TAP_PREV[m_filt] + 32) >>> 6;
    sum  = base + pred;
    if (sum > 32767)       sum = 32767;
    else if (sum < -32768) sum = -32768;
    m_h2 = m_h1;
    m_h1 = SampleW'(sum);
    return SampleW'(sum);
  endfunction

  // advance the model by one accepted byte and queue the samples it yields
  function automatic void decode_byte(input logic [ByteW-1:0] d, input logic s,
                                      input logic typed,
                                      input logic signed [SampleW-1:0] lo,
                                      input logic signed [SampleW-1:0] hi);
    logic [PosW-1:0] pos;
    pcm_result_t     r;
    if (s) begin
      m_pos = POS_HEADER;
      m_h1  = '0;
      m_h2  = '0;
    end
    pos   = m_pos;
    m_pos = m_pos + 4'd1;
    if (pos == POS_HEADER) begin
      m_shift = d[3:0];
      m_filt  = (d[6:4] > FILT_MAX) ? '0 : d[6:4];
    end else if (pos == POS_FLAGS) begin
      m_flags = d[FlagW-1:0];
    end else begin
      for (int k = 0; k < 2; k++) begin
        r.pcm          = next_sample(k == 0 ? d[3:0] : d[7:4]);
        if (typed) r.pcm = (k == 0) ? lo : hi;
        r.last_of_pair = (k == 1);
        r.start_mark   = (pos == POS_FIRST) && (k == 0) && m_flags[FLAG_START];
        r.end_mark     = (pos == POS_LAST) && (k == 1) && m_flags[FLAG_END];
        r.loop_rep     = r.end_mark && m_flags[FLAG_REPEAT];
        pcm_expected_q = {pcm_expected_q, r};
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Byte source. valid is only dropped when a gap follows, so a back-to-back
  // transaction never sees valid lowered and raised in one step.
  // --------------------------------------------------------------------------
  task automatic stream_byte(input logic [ByteW-1:0] d, input logic s,
                             input logic typed,
                             input logic signed [SampleW-1:0] lo,
                             input logic signed [SampleW-1:0] hi);
    repeat (send_gap) @(posedge clk_i);
    in_if.valid        <= 1'b1;
    in_if.data_byte    <= d;
    in_if.stream_start <= s;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    decode_byte(d, s, typed, lo, hi);
    n_sent++;
    send_gap = calm ? 0 : $urandom_range(0, 7);
    if (send_gap > 0) in_if.valid <= 1'b0;
  endtask

  // stop offering and wait until every queued sample has come out
  task automatic drain_samples();
    if (send_gap == 0) in_if.valid <= 1'b0;
    send_gap = 0;
    do @(posedge clk_i); while (pcm_expected_q.size() != 0);
  endtask

  // random block: header and flags, then usually all 14 data bytes; a short
  // block or a stray byte leaves the framing off, so the next header resyncs
  task automatic random_block(inout bit broken);
    int len;
    if ($urandom_range(0, 9) == 0) begin
      stream_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0, '0);
      broken = 1'b1;
    end else begin
      stream_byte(8'($urandom_range(0, 255)), broken || ($urandom_range(0, 3) == 0),
                  1'b0, '0, '0);
      stream_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0, '0);
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 13) : 14;
      repeat (len) stream_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0, '0);
      broken = (len < 14);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sample sink: random stalls, one long hold-off on request, field checks
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  initial begin : sample_sink
    int          stall;
    pcm_result_t e;
    wait (tb_live);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      stall = calm ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      if (pcm_expected_q.size() == 0) begin
        $error("pcm_sample %0d arrived with no sample pending", out_if.pcm_sample);
        n_errors++;
      end else begin
        e = pcm_expected_q.pop_front();
        check_field("pcm_sample", int'(e.pcm), int'(out_if.pcm_sample));
        check_field("last_of_pair", e.last_of_pair, out_if.last_of_pair);
        check_field("loop_start_here", e.start_mark, out_if.loop_start_here);
        check_field("loop_end_here", e.end_mark, out_if.loop_end_here);
        check_field("loop_repeat", e.loop_rep, out_if.loop_repeat);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without a transaction on either channel ends the run
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int n_blocks;
    bit broken;
    in_if.valid        <= 1'b0;
    in_if.data_byte    <= '0;
    in_if.stream_start <= 1'b0;
    out_if.ready       <= 1'b0;
    n_blocks = 0;
    broken   = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni  <= 1'b1;
    tb_live  = 1'b1;

    // directed table, back to back first so the sink sees a full-rate burst
    calm = 1'b1;
    foreach (DIR_TAB[i]) begin
      stream_byte(DIR_TAB[i].data, DIR_TAB[i].start, DIR_TAB[i].typed,
                  DIR_TAB[i].lo, DIR_TAB[i].hi);
      if (i == 15) calm = 1'b0;
    end

    // random blocks; a calm block now and then runs with no idling at all
    while (n_sent < DIR_N + RAND_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      if (n_blocks == 20) hold_req = 1'b1;   // sink backs off, input must stall
      if (n_blocks == 50) drain_samples();    // source pauses until all is out
      random_block(broken);
      n_blocks++;
    end

    drain_samples();
    repeat (LINGER) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
